/* rtl/mbrx_pkg.sv */
// ----------------------------------------------------------------------------
// mbrx_pkg: shared definitions of the Modbus RTU frame receiver
// Function codes, frame length constants, register indexes, the result
// word type and the byte-wide Modbus CRC-16 update.
// ----------------------------------------------------------------------------
package mbrx_pkg;

  localparam int BYTE_W      = 8;
  localparam int SLOT_W      = 4;
  localparam int INDEX_W     = 8;
  localparam int HOLD_W      = 14;
  localparam int EXP_LEN_W   = 18;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 14;

  // Modbus function codes that the receiver accepts.
  localparam logic [BYTE_W-1:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [BYTE_W-1:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [BYTE_W-1:0] FUNC_WRITE_MULTI  = 8'h10;

  // Fixed frame length of 0x03 and 0x06, base length of 0x10.
  localparam logic [EXP_LEN_W-1:0] FIXED_FRAME_LEN  = 18'd8;
  localparam logic [EXP_LEN_W-1:0] MULTI_FRAME_BASE = 18'd9;

  // Frame byte positions of the register count in a 0x10 frame.
  localparam int COUNT_HIGH_POS = 4;
  localparam int COUNT_LOW_POS  = 5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT     = 1'd1;
  localparam logic [BYTE_W-1:0]      DEVICE_ADDRESS_RST = 8'h01;
  localparam logic [HOLD_W-1:0]      HOLD_LIMIT_RST     = 14'd10000;

  // One result word.
  typedef struct packed {
    logic              store_valid;
    logic [SLOT_W-1:0] store_slot;
    logic [INDEX_W-1:0] store_index;
    logic [BYTE_W-1:0] store_data;
    logic              frame_end;
    logic              frame_ok;
    logic [SLOT_W-1:0] ready_slot;
    logic              length_error;
    logic              modem_hold;
  } result_t;

  // Reflected Modbus CRC-16, one byte per call.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [BYTE_W-1:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/modbus_rtu_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_core: Modbus RTU frame receiver with CRC-16 check
// Timing: the result word is registered, valid the cycle after its byte.
// Throughput: one byte word per cycle while results are taken, set by the
// single registered pass of the CRC update, length compare and slot logic.
// Reset: synchronous; hunting for the address, CRC 0xFFFF, slots 0, no hold,
// device address 1 and hold limit 10000.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_core #(
  parameter int SLOT_COUNT  = 10,
  parameter int FRAME_BYTES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Received byte words.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mbrx_pkg::BYTE_W-1:0]          rx_byte,
  // Result words, one for every received byte.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 store_valid,
  output logic [mbrx_pkg::SLOT_W-1:0]          store_slot,
  output logic [mbrx_pkg::INDEX_W-1:0]         store_index,
  output logic [mbrx_pkg::BYTE_W-1:0]          store_data,
  output logic                                 frame_end,
  output logic                                 frame_ok,
  output logic [mbrx_pkg::SLOT_W-1:0]          ready_slot,
  output logic                                 length_error,
  output logic                                 modem_hold,
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbrx_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mbrx_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import mbrx_pkg::*;

  // The byte position never holds FRAME_BYTES itself: reaching the expected
  // length (at most FRAME_BYTES) sends the receiver back to hunting.
  localparam int POS_W = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [EXP_LEN_W-1:0] FRAME_LIMIT = EXP_LEN_W'(FRAME_BYTES);
  localparam logic [SLOT_W-1:0]    SLOT_LAST   = SLOT_W'(SLOT_COUNT - 1);

  // Configuration registers.
  logic [BYTE_W-1:0] device_address;
  logic [HOLD_W-1:0] hold_limit;

  // Receiver state.
  logic [POS_W-1:0]     byte_position, byte_position_next;
  logic [EXP_LEN_W-1:0] expected_length, expected_length_next;
  logic                 is_multi_write, is_multi_write_next;
  logic [BYTE_W-1:0]    count_high_byte, count_high_byte_next;
  logic [15:0]          running_crc, running_crc_next;
  logic                 low_crc_match, low_crc_match_next;
  logic [SLOT_W-1:0]    write_slot, write_slot_next;
  logic [SLOT_W-1:0]    last_good_slot, last_good_slot_next;
  logic                 hold_active, hold_active_next;
  logic [HOLD_W-1:0]    hold_count, hold_count_next;

  // Output register.
  result_t result, result_next;
  logic    in_fire;

  // The output register frees up in the same cycle that its word is taken,
  // so bytes stream through at one word per cycle while out_ready stays high.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Frame parsing for one byte. Position 0 hunts for the device address,
  // position 1 takes the function code, and later positions feed the CRC
  // until the two trailing CRC bytes, which are compared low byte first.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [EXP_LEN_W-1:0] idx;
    logic [EXP_LEN_W-1:0] pos_plus1;
    logic [EXP_LEN_W-1:0] exp_len;
    logic                 good;
    logic                 len_err;
    logic                 f_end;
    logic                 f_ok;
    logic                 hunt;
    logic [HOLD_W-1:0]    cnt_inc;

    idx       = EXP_LEN_W'(byte_position);
    pos_plus1 = idx + 18'd1;
    good      = 1'b0;
    len_err   = 1'b0;
    f_end     = 1'b0;
    f_ok      = 1'b0;
    hunt      = 1'b0;
    exp_len   = expected_length;
    cnt_inc   = hold_count + 14'd1;

    byte_position_next   = byte_position;
    expected_length_next = expected_length;
    is_multi_write_next  = is_multi_write;
    count_high_byte_next = count_high_byte;
    running_crc_next     = running_crc;
    low_crc_match_next   = low_crc_match;
    write_slot_next      = write_slot;
    last_good_slot_next  = last_good_slot;
    hold_active_next     = hold_active;
    hold_count_next      = hold_count;

    result_next              = '0;
    result_next.store_slot   = write_slot;

    if (byte_position == '0) begin
      if (rx_byte == device_address) begin
        result_next.store_valid = 1'b1;
        result_next.store_data  = rx_byte;
        running_crc_next        = crc_feed(CRC_INIT, rx_byte);
        byte_position_next      = POS_W'(1);
        expected_length_next    = '0;
        is_multi_write_next     = 1'b0;
      end
    end else if (byte_position == POS_W'(1)) begin
      if (rx_byte == FUNC_READ_HOLDING || rx_byte == FUNC_WRITE_SINGLE ||
          rx_byte == FUNC_WRITE_MULTI) begin
        result_next.store_valid = 1'b1;
        result_next.store_index = INDEX_W'(1);
        result_next.store_data  = rx_byte;
        running_crc_next        = crc_feed(running_crc, rx_byte);
        byte_position_next      = POS_W'(2);
        is_multi_write_next     = (rx_byte == FUNC_WRITE_MULTI);
        expected_length_next    = (rx_byte == FUNC_WRITE_MULTI) ? '0 : FIXED_FRAME_LEN;
        // A single register write never holds off the modem.
        if (rx_byte != FUNC_WRITE_SINGLE) begin
          hold_active_next = 1'b1;
        end
      end else begin
        hunt = 1'b1;
      end
    end else begin
      result_next.store_valid = 1'b1;
      result_next.store_index = INDEX_W'(byte_position);
      result_next.store_data  = rx_byte;

      if (expected_length == '0 || idx + 18'd2 < expected_length) begin
        running_crc_next = crc_feed(running_crc, rx_byte);
      end else if (idx + 18'd2 == expected_length) begin
        low_crc_match_next = (rx_byte == running_crc[7:0]);
      end else begin
        good = low_crc_match && (rx_byte == running_crc[15:8]);
      end

      // The register count of a 0x10 frame fixes its length.
      if (is_multi_write) begin
        if (idx == EXP_LEN_W'(COUNT_HIGH_POS)) begin
          count_high_byte_next = rx_byte;
        end
        if (idx == EXP_LEN_W'(COUNT_LOW_POS)) begin
          exp_len = MULTI_FRAME_BASE + {1'b0, count_high_byte, rx_byte, 1'b0};
          expected_length_next = exp_len;
          len_err = (exp_len > FRAME_LIMIT);
        end
      end

      if (len_err) begin
        hunt = 1'b1;
      end else begin
        byte_position_next = POS_W'(pos_plus1);
        if (exp_len != '0 && pos_plus1 >= exp_len) begin
          f_end = 1'b1;
          hunt  = 1'b1;
          if (good) begin
            f_ok                = 1'b1;
            last_good_slot_next = write_slot;
            write_slot_next     = (write_slot >= SLOT_LAST) ? '0 : write_slot + 4'd1;
          end
        end
      end
    end

    if (hunt) begin
      byte_position_next   = '0;
      expected_length_next = '0;
      is_multi_write_next  = 1'b0;
      count_high_byte_next = '0;
      running_crc_next     = CRC_INIT;
      low_crc_match_next   = 1'b0;
    end

    // The hold counts every byte event, including the one that raised it.
    if (hold_active_next) begin
      hold_count_next = cnt_inc;
      if (cnt_inc >= hold_limit) begin
        hold_active_next = 1'b0;
        hold_count_next  = '0;
      end
    end

    result_next.frame_end    = f_end;
    result_next.frame_ok     = f_ok;
    result_next.length_error = len_err;
    result_next.ready_slot   = last_good_slot_next;
    result_next.modem_hold   = hold_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address  <= DEVICE_ADDRESS_RST;
      hold_limit      <= HOLD_LIMIT_RST;
      byte_position   <= '0;
      expected_length <= '0;
      is_multi_write  <= 1'b0;
      count_high_byte <= '0;
      running_crc     <= CRC_INIT;
      low_crc_match   <= 1'b0;
      write_slot      <= '0;
      last_good_slot  <= '0;
      hold_active     <= 1'b0;
      hold_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEVICE_ADDRESS: device_address <= cfg_data[BYTE_W-1:0];
          REG_HOLD_LIMIT:     hold_limit     <= cfg_data[HOLD_W-1:0];
          default:            ;
        endcase
      end
      if (in_fire) begin
        byte_position   <= byte_position_next;
        expected_length <= expected_length_next;
        is_multi_write  <= is_multi_write_next;
        count_high_byte <= count_high_byte_next;
        running_crc     <= running_crc_next;
        low_crc_match   <= low_crc_match_next;
        write_slot      <= write_slot_next;
        last_good_slot  <= last_good_slot_next;
        hold_active     <= hold_active_next;
        hold_count      <= hold_count_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is only read while out_valid is set.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign store_valid  = result.store_valid;
  assign store_slot   = result.store_slot;
  assign store_index  = result.store_index;
  assign store_data   = result.store_data;
  assign frame_end    = result.frame_end;
  assign frame_ok     = result.frame_ok;
  assign ready_slot   = result.ready_slot;
  assign length_error = result.length_error;
  assign modem_hold   = result.modem_hold;

  // A good frame is always a completed frame, and it names the slot it was
  // stored in.
  a_ok_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> frame_end && store_valid && ready_slot == store_slot)
    else $error("frame_ok without a matching frame end");

  // A dropped oversize frame never also completes.
  a_len_err_no_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> !frame_end && store_valid)
    else $error("length_error together with frame_end");

  // Bytes that are not stored report index and data as zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_valid |-> store_index == '0 && store_data == '0 && !frame_end)
    else $error("unstored byte carries payload");

  // The slot ring stays inside the configured number of slots.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_LAST && last_good_slot <= SLOT_LAST)
    else $error("slot pointer out of range");

  // Hunting always starts from a fresh CRC.
  a_hunt_crc: assert property (@(posedge clk) disable iff (rst)
    byte_position == '0 |-> running_crc == CRC_INIT && expected_length == '0)
    else $error("hunting state not cleared");

endmodule

/* sim/modbus_rtu_frame_receiver_core_test.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_core_test: self-checking bench of the frame receiver
// Streams Modbus RTU bytes into the core: good frames of every function,
// frames with a broken CRC, truncated and oversized frames, wrong function
// codes and line noise. Random handshake pressure is applied on both sides,
// and every result word is checked against a predictor of the receiver.
// ----------------------------------------------------------------------------

import mbrx_pkg::*;

class frame_scoreboard;

  // Configuration as last written.
  logic [BYTE_W-1:0] dev_addr;
  logic [HOLD_W-1:0] hold_limit;

  // Receiver state.
  int                pos;
  int                exp_len;
  bit                multi;
  logic [7:0]        count_hi;
  logic [15:0]       crc;
  bit                low_ok;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] good_slot;
  bit                hold_on;
  logic [HOLD_W-1:0] hold_cnt;

  int slot_count;
  int frame_bytes;

  // Result words still due from the core, oldest first.
  result_t awaited[$];

  int mismatches    = 0;
  int words_checked = 0;
  int bytes_stored  = 0;
  int good_frames   = 0;
  int bad_frames    = 0;
  int length_drops  = 0;
  int hold_releases = 0;

  function new(int slots, int max_bytes);
    slot_count  = slots;
    frame_bytes = max_bytes;
    dev_addr    = DEVICE_ADDRESS_RST;
    hold_limit  = HOLD_LIMIT_RST;
    write_slot  = '0;
    good_slot   = '0;
    hold_on     = 1'b0;
    hold_cnt    = '0;
    hunt();
  endfunction

  function void hunt();
    pos      = 0;
    exp_len  = 0;
    multi    = 1'b0;
    count_hi = '0;
    crc      = CRC_INIT;
    low_ok   = 1'b0;
  endfunction

  // Bit-serial form of the reflected Modbus CRC-16.
  static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function bit at_rest();
    return pos == 0;
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_DEVICE_ADDRESS) begin
      dev_addr = val[BYTE_W-1:0];
    end else if (idx == REG_HOLD_LIMIT) begin
      hold_limit = val;
    end
  endfunction

  // Advances the receiver by one accepted byte and queues the word it yields.
  function void receive_byte(logic [7:0] rx);
    result_t w;
    int      idx;
    bit      good;
    w            = '0;
    w.store_slot = write_slot;
    if (pos == 0) begin
      if (rx == dev_addr) begin
        w.store_valid = 1'b1;
        w.store_data  = rx;
        crc           = crc_byte(CRC_INIT, rx);
        pos           = 1;
        exp_len       = 0;
        multi         = 1'b0;
      end
    end else if (pos == 1) begin
      if (rx == FUNC_READ_HOLDING || rx == FUNC_WRITE_SINGLE || rx == FUNC_WRITE_MULTI) begin
        w.store_valid = 1'b1;
        w.store_index = 8'd1;
        w.store_data  = rx;
        crc           = crc_byte(crc, rx);
        pos           = 2;
        multi         = (rx == FUNC_WRITE_MULTI);
        exp_len       = multi ? 0 : int'(FIXED_FRAME_LEN);
        if (rx != FUNC_WRITE_SINGLE) begin
          hold_on = 1'b1;
        end
      end else begin
        hunt();
      end
    end else begin
      idx           = pos;
      good          = 1'b0;
      w.store_valid = 1'b1;
      w.store_index = idx[INDEX_W-1:0];
      w.store_data  = rx;
      if (exp_len == 0 || idx + 2 < exp_len) begin
        crc = crc_byte(crc, rx);
      end else if (idx + 2 == exp_len) begin
        low_ok = (rx == crc[7:0]);
      end else begin
        good = low_ok && (rx == crc[15:8]);
      end
      if (multi) begin
        if (idx == COUNT_HIGH_POS) begin
          count_hi = rx;
        end
        if (idx == COUNT_LOW_POS) begin
          exp_len = int'(MULTI_FRAME_BASE) + 2 * int'({count_hi, rx});
          if (exp_len > frame_bytes) begin
            w.length_error = 1'b1;
          end
        end
      end
      if (w.length_error) begin
        length_drops++;
        hunt();
      end else begin
        pos = idx + 1;
        if (exp_len != 0 && pos >= exp_len) begin
          w.frame_end = 1'b1;
          if (good) begin
            w.frame_ok = 1'b1;
            good_slot  = write_slot;
            write_slot = (write_slot + 1 >= slot_count) ? '0 : write_slot + 1'b1;
            good_frames++;
          end else begin
            bad_frames++;
          end
          hunt();
        end
      end
    end
    if (hold_on) begin
      hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt >= hold_limit) begin
        hold_on  = 1'b0;
        hold_cnt = '0;
        hold_releases++;
      end
    end
    w.ready_slot = good_slot;
    w.modem_hold = hold_on;
    if (w.store_valid) begin
      bytes_stored++;
    end
    awaited.push_back(w);
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 50) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task compare_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d %s got 0x%0h expected 0x%0h",
                                words_checked, name, got, want));
    end
  endtask

  task check_word(result_t got);
    result_t want;
    if (awaited.size() == 0) begin
      report_mismatch("result word with no byte waiting for it");
      return;
    end
    want = awaited.pop_front();
    compare_field("store_valid", got.store_valid, want.store_valid);
    compare_field("store_slot", got.store_slot, want.store_slot);
    compare_field("store_index", got.store_index, want.store_index);
    compare_field("store_data", got.store_data, want.store_data);
    compare_field("frame_end", got.frame_end, want.frame_end);
    compare_field("frame_ok", got.frame_ok, want.frame_ok);
    compare_field("ready_slot", got.ready_slot, want.ready_slot);
    compare_field("length_error", got.length_error, want.length_error);
    compare_field("modem_hold", got.modem_hold, want.modem_hold);
    words_checked++;
  endtask

endclass

module modbus_rtu_frame_receiver_core_test;

  localparam int SLOT_COUNT   = 10;
  localparam int FRAME_BYTES  = 256;
  // Far above the slowest legal run.
  localparam int LIMIT_CYCLES = 400000;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic [BYTE_W-1:0]        rx_byte      = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic                     store_valid;
  logic [SLOT_W-1:0]        store_slot;
  logic [INDEX_W-1:0]       store_index;
  logic [BYTE_W-1:0]        store_data;
  logic                     frame_end;
  logic                     frame_ok;
  logic [SLOT_W-1:0]        ready_slot;
  logic                     length_error;
  logic                     modem_hold;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index    = '0;
  logic [CFG_DATA_W-1:0]    cfg_data     = '0;

  frame_scoreboard sb = new(SLOT_COUNT, FRAME_BYTES);

  // Idle rates of the two sides in percent, and a flag that switches both
  // off for a frame now and then so that gap-free stretches occur in every
  // phase.
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  bit calm            = 1'b0;
  // Cycles for which the result side refuses words, counted down by the
  // result process itself.
  int hold_off_cycles = 0;
  int cycles          = 0;

  modbus_rtu_frame_receiver_core #(
    .SLOT_COUNT (SLOT_COUNT),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .store_valid (store_valid),
    .store_slot  (store_slot),
    .store_index (store_index),
    .store_data  (store_data),
    .frame_end   (frame_end),
    .frame_ok    (frame_ok),
    .ready_slot  (ready_slot),
    .length_error(length_error),
    .modem_hold  (modem_hold),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offers one byte word and returns at the edge that accepts it. Valid is
  // only dropped when an idle gap is taken, so back-to-back words keep it
  // high without a second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.receive_byte(b);
  endtask

  // Builds a frame for the current device address. A 0x10 frame whose count
  // makes it longer than a slot is cut after the count, since the core drops
  // it there. The corrupt flag flips one bit of one CRC byte; a nonzero keep
  // truncates the frame to that many bytes.
  task automatic send_frame(input logic [7:0] func, input int count,
                            input bit corrupt, input int keep);
    logic [7:0]  f[$];
    logic [15:0] c;
    int          i;
    int          last;
    bit          fits;
    fits = (func != FUNC_WRITE_MULTI) || (9 + 2 * count <= FRAME_BYTES);
    f.push_back(sb.dev_addr);
    f.push_back(func);
    if (func == FUNC_WRITE_MULTI) begin
      f.push_back(8'($urandom));
      f.push_back(8'($urandom));
      f.push_back(count[15:8]);
      f.push_back(count[7:0]);
      if (fits) begin
        f.push_back(8'(2 * count));
        for (i = 0; i < 2 * count; i++) begin
          f.push_back(8'($urandom));
        end
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        f.push_back(8'($urandom));
      end
    end
    if (fits) begin
      c = CRC_INIT;
      for (i = 0; i < f.size(); i++) begin
        c = crc_feed(c, f[i]);
      end
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
      if (corrupt) begin
        last    = f.size() - 1 - $urandom_range(1);
        f[last] = f[last] ^ 8'(1 << $urandom_range(7));
      end
    end
    if (keep > 0 && keep < f.size()) begin
      f = f[0:keep-1];
    end
    for (i = 0; i < f.size(); i++) begin
      send_byte(f[i]);
    end
  endtask

  // Register writes happen only while the core is idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering bytes until every result word is back, then lets the
  // registered result stage settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One random piece of traffic. Most of it is well-formed frames with random
  // content; the rest breaks frames in the ways the receiver must survive.
  // Afterwards the line is fed until the receiver is hunting again, so that
  // the next frame starts clean.
  task automatic random_frame();
    int         pick;
    int         i;
    logic [7:0] code;
    logic [7:0] func;
    pick = $urandom_range(99);
    calm = ($urandom_range(7) == 0);
    case ($urandom_range(2))
      0:       func = FUNC_READ_HOLDING;
      1:       func = FUNC_WRITE_SINGLE;
      default: func = FUNC_WRITE_MULTI;
    endcase
    if (pick < 28) begin
      send_frame(FUNC_READ_HOLDING, 0, 1'b0, 0);
    end else if (pick < 42) begin
      send_frame(FUNC_WRITE_SINGLE, 0, 1'b0, 0);
    end else if (pick < 66) begin
      send_frame(FUNC_WRITE_MULTI,
                 ($urandom_range(9) == 0) ? $urandom_range(123) : $urandom_range(6),
                 1'b0, 0);
    end else if (pick < 76) begin
      send_frame(func, $urandom_range(6), 1'b1, 0);
    end else if (pick < 82) begin
      send_frame(FUNC_WRITE_MULTI, $urandom_range(65535, 124), 1'b0, 0);
    end else if (pick < 89) begin
      // Address followed by something that is not a function code, at times
      // the address again.
      send_byte(sb.dev_addr);
      code = sb.dev_addr;
      if ($urandom_range(2) != 0 || code == FUNC_READ_HOLDING ||
          code == FUNC_WRITE_SINGLE || code == FUNC_WRITE_MULTI) begin
        do begin
          code = 8'($urandom);
        end while (code == FUNC_READ_HOLDING || code == FUNC_WRITE_SINGLE ||
                   code == FUNC_WRITE_MULTI);
      end
      send_byte(code);
    end else if (pick < 95) begin
      send_frame(func, $urandom_range(6), 1'b0, $urandom_range(7, 1));
    end else begin
      for (i = $urandom_range(6, 1); i > 0; i--) begin
        send_byte(8'($urandom));
      end
    end
    while (!sb.at_rest()) begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic run_phase(input int stored_goal);
    while (sb.bytes_stored < stored_goal) begin
      random_frame();
    end
  endtask

  // Result side: checks each accepted word and chooses out_ready for the
  // next cycle, honoring a requested hold-off first.
  initial begin
    result_t seen;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        seen = {store_valid, store_slot, store_index, store_data, frame_end,
                frame_ok, ready_slot, length_error, modem_hold};
        sb.check_word(seen);
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("modbus_rtu_frame_receiver_core test failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed traffic with the reset configuration: noise at both byte
    // extremes, a wrong function code, a repeated address, a good 0x03 frame
    // that raises the hold, a 0x06 frame with a broken CRC, and a 0x10 header
    // announcing the largest count while the hold is already running.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(DEVICE_ADDRESS_RST);
    send_byte(8'h7F);
    send_byte(DEVICE_ADDRESS_RST);
    send_byte(DEVICE_ADDRESS_RST);
    send_frame(FUNC_READ_HOLDING, 0, 1'b0, 0);
    send_frame(FUNC_WRITE_SINGLE, 0, 1'b1, 0);
    send_frame(FUNC_WRITE_MULTI, 16'hFFFF, 1'b0, 0);
    drain();

    // Phase one, no idling: the hold limit at its minimum, so the hold drops
    // on the step that raises it. The largest frame that fits a slot and the
    // smallest one that does not come first.
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'(8'hA5));
    write_reg(REG_HOLD_LIMIT, CFG_DATA_W'(1));
    send_frame(FUNC_WRITE_MULTI, 123, 1'b0, 0);
    send_frame(FUNC_WRITE_MULTI, 124, 1'b0, 0);
    run_phase(sb.bytes_stored + 60);
    drain();

    // Phase two, the sender idles: lowest address and the largest limit, so
    // the hold stays up and its count carries into the next phase.
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'(8'h00));
    write_reg(REG_HOLD_LIMIT, CFG_DATA_W'(16383));
    send_idle_pct = 53;
    run_phase(sb.bytes_stored + 80);
    drain();

    // Phase three, the receiver stalls: highest address and a small limit,
    // which lands below the count left running by phase two. The result side
    // first refuses words for a long stretch while a long frame is offered,
    // so that the core backs up into its input.
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'(8'hFF));
    write_reg(REG_HOLD_LIMIT, CFG_DATA_W'($urandom_range(60, 3)));
    send_idle_pct   = 0;
    recv_stall_pct  = 53;
    hold_off_cycles = 150;
    calm            = 1'b1;
    send_frame(FUNC_WRITE_MULTI, 20, 1'b0, 0);
    run_phase(sb.bytes_stored + 80);
    drain();

    // Phase four, light idling on both sides: a random address written with
    // random upper data bits, which the address register ignores. Halfway the
    // sender waits until every result word is back before going on.
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'($urandom));
    write_reg(REG_HOLD_LIMIT, CFG_DATA_W'($urandom_range(400, 1)));
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_phase(sb.bytes_stored + 40);
    drain();
    run_phase(sb.bytes_stored + 40);
    drain();

    $display("Covered %0d result words with %0d stored bytes: %0d good frames, %0d bad CRC,",
             sb.words_checked, sb.bytes_stored, sb.good_frames, sb.bad_frames);
    $display("%0d oversized frames dropped, %0d hold releases, %0d mismatches.",
             sb.length_drops, sb.hold_releases, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("modbus_rtu_frame_receiver_core test passed");
    end else begin
      $display("modbus_rtu_frame_receiver_core test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mbrx_pkg.sv
rtl/modbus_rtu_frame_receiver_core.sv
sim/modbus_rtu_frame_receiver_core_test.sv
